>>> rtl/sd_spi_init_command_engine_top_defines.svh
// assertion macros for the sd spi command engine checker
// no dependencies
`ifndef SD_SPI_INIT_COMMAND_ENGINE_TOP_DEFINES_SVH
`define SD_SPI_INIT_COMMAND_ENGINE_TOP_DEFINES_SVH
// assert that a implies b on the same edge
`define SDE_ASSERT_IMP(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error("lbl");
// assert that a implies b on the next edge
`define SDE_ASSERT_NXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error("lbl");
`endif

>>> rtl/sdspi_pkg.sv
// shared types and constants for the sd spi command engine
// no dependencies
package sdspi_pkg;
	typedef enum logic [3:0] {
		P_IDLE, P_CMD0, P_CMD8, P_R7, P_CMD55, P_ACMD41, P_CMD58, P_OCR,
		P_CMD9, P_START, P_CSD, P_SINGLE
	} phase_t;
	typedef enum logic [1:0] {CS_IDLEWAIT, CS_SEND, CS_RESP} cstage_t;
	localparam logic [2:0] CMD_INIT = 3'd0;
	localparam logic [2:0] CMD_SIZE = 3'd1;
	localparam logic [2:0] CMD_SINGLE = 3'd2;
	localparam logic [2:0] CMD_RX = 3'd3;
	localparam logic [2:0] CMD_TICK = 3'd4;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;
	localparam logic [15:0] INIT_TMO_RST = 16'd2000;
	localparam logic [15:0] CMD_TMO_RST = 16'd300;
	localparam logic REG_INIT_TMO = 1'b0;
	localparam logic REG_CMD_TMO = 1'b1;
	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_byte;
		logic select_active;
		logic select_card;
		logic done_res;
		logic [1:0] status;
		logic [7:0] response_byte;
		logic [32:0] card_size_blocks;
	} result_t;
	typedef struct packed {
		logic [2:0] command;
		logic card;
		logic [5:0] cmd_index;
		logic [31:0] cmd_arg;
		logic [7:0] rx_byte;
		logic card_present;
	} item_t;
endpackage

>>> rtl/sd_spi_init_command_engine_top.sv
// one event word per cycle while in_stall is low; a word that yields a result has it registered in the output stage
// throughput one word per cycle while the skid stage is empty, limited by the single sequencer state register
// input stalls only while the output skid stage holds a word
// arst_n clears sequencer and output valids and resets timeouts to their defaults (2000 and 300 ticks)
// top level: sequencer plus output register, depends on sdspi_pkg
// instantiates sdspi_core and sdspi_outreg
module sd_spi_init_command_engine_top import sdspi_pkg::*; #(
	parameter logic [15:0] INIT_TMO_DEFAULT = INIT_TMO_RST,
	parameter logic [15:0] CMD_TMO_DEFAULT = CMD_TMO_RST
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] command,
	input logic card,
	input logic [5:0] cmd_index,
	input logic [31:0] cmd_arg,
	input logic [7:0] rx_byte,
	input logic card_present,
	output logic out_valid,
	input logic out_stall,
	output logic tx_valid,
	output logic [7:0] tx_byte,
	output logic select_active,
	output logic select_card,
	output logic done_res,
	output logic [1:0] status,
	output logic [7:0] response_byte,
	output logic [32:0] card_size_blocks,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	logic [15:0] init_tmo_q, cmd_tmo_q;
	logic go, has_res, can_take;
	item_t it;
	result_t res, ores;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_tmo_q <= INIT_TMO_DEFAULT; cmd_tmo_q <= CMD_TMO_DEFAULT;
		end else if (cfg_we) begin
			if (cfg_index == REG_INIT_TMO) init_tmo_q <= cfg_data;
			else cmd_tmo_q <= cfg_data;
		end
	end
	assign in_stall = !can_take;
	assign go = in_valid && can_take;
	assign it = '{command: command, card: card, cmd_index: cmd_index, cmd_arg: cmd_arg,
		rx_byte: rx_byte, card_present: card_present};
	sdspi_core u_core (.clk, .arst_n, .go, .it, .init_tmo(init_tmo_q),
		.cmd_tmo(cmd_tmo_q), .has_res, .res);
	sdspi_outreg u_out (.clk, .arst_n, .in_vld(go && has_res), .in_res(res), .can_take,
		.out_vld(out_valid), .out_res(ores), .out_stall);
	assign tx_valid = ores.tx_valid;
	assign tx_byte = ores.tx_byte;
	assign select_active = ores.select_active;
	assign select_card = ores.select_card;
	assign done_res = ores.done_res;
	assign status = ores.status;
	assign response_byte = ores.response_byte;
	assign card_size_blocks = ores.card_size_blocks;
endmodule

>>> rtl/sdspi_core.sv
// sequencer state and per-event next-state logic
// depends on sdspi_pkg
module sdspi_core import sdspi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input item_t it,
	input logic [15:0] init_tmo,
	input logic [15:0] cmd_tmo,
	output logic has_res,
	output result_t res
);
	phase_t phase_q, ph;
	cstage_t stage_q, st;
	logic [15:0] wait_q, loop_q, wt, lp;
	logic [4:0] cnt_q, cn;
	logic [7:0] resp_q, rs;
	logic [31:0] cap_q, cp;
	logic [5:0] idx_q, ix;
	logic [31:0] arg_q, ag;
	logic card_q, cd;
	logic [15:0] ctmo, itmo;
	assign ctmo = (cmd_tmo == '0) ? 16'd1 : cmd_tmo;
	assign itmo = (init_tmo == '0) ? 16'd1 : init_tmo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; stage_q <= CS_IDLEWAIT; wait_q <= '0; loop_q <= '0;
			cnt_q <= '0; resp_q <= 8'hFF; cap_q <= '0; idx_q <= '0; arg_q <= '0;
			card_q <= 1'b0;
		end else if (go) begin
			phase_q <= ph; stage_q <= st; wait_q <= wt; loop_q <= lp; cnt_q <= cn;
			resp_q <= rs; cap_q <= cp; idx_q <= ix; arg_q <= ag; card_q <= cd;
		end
	end

	always_comb begin
		logic byte_out, fin, need_start, need_poll, need_after;
		logic [7:0] b;
		logic [1:0] fst;
		logic [32:0] fsz;
		logic [5:0] si;
		logic [31:0] sa;
		logic [4:0] c1;
		logic [31:0] cw;
		ph = phase_q; st = stage_q; wt = wait_q; lp = loop_q; cn = cnt_q;
		rs = resp_q; cp = cap_q; ix = idx_q; ag = arg_q; cd = card_q;
		byte_out = 1'b0; fin = 1'b0; b = 8'hFF; fst = ST_OK; fsz = '0;
		need_start = 1'b0; need_poll = 1'b0; need_after = 1'b0;
		si = '0; sa = '0; has_res = 1'b0;
		c1 = cnt_q + 5'd1; cw = '0;
		case (it.command)
			CMD_TICK: begin
				if (wait_q != 16'hFFFF) wt = wait_q + 16'd1;
				if (loop_q != 16'hFFFF) lp = loop_q + 16'd1;
			end
			CMD_INIT, CMD_SIZE, CMD_SINGLE: begin
				if (phase_q == P_IDLE) begin
					has_res = 1'b1; cd = it.card; rs = 8'hFF;
					if (it.command == CMD_SINGLE) begin
						ph = P_SINGLE; need_start = 1'b1; si = it.cmd_index; sa = it.cmd_arg;
					end else if (!it.card_present) begin
						fin = 1'b1; fst = ST_ABSENT;
					end else if (it.command == CMD_SIZE) begin
						ph = P_CMD9; need_start = 1'b1; si = 6'd9;
					end else begin
						lp = '0;
						if (16'd0 < itmo) begin
							ph = P_CMD0; need_start = 1'b1; si = 6'd0;
						end else begin
							fin = 1'b1; fst = ST_FAIL;
						end
					end
				end
			end
			CMD_RX: begin
				if (phase_q != P_IDLE) begin
					has_res = 1'b1;
					case (phase_q)
						P_R7: begin
							cw = {cap_q[23:0], it.rx_byte}; cp = cw; cn = c1;
							if (c1 < 5'd4) byte_out = 1'b1;
							else if (cw[7:0] != 8'hAA) begin fin = 1'b1; fst = ST_FAIL; end
							else if (!it.card_present) begin fin = 1'b1; fst = ST_ABSENT; end
							else if (16'd0 < itmo) begin
								lp = '0; ph = P_CMD55; need_start = 1'b1; si = 6'd55;
							end else begin
								lp = '0; fin = 1'b1; fst = ST_FAIL;
							end
						end
						P_OCR: begin
							cw = (cnt_q == 5'd0) ? {24'd0, it.rx_byte} : cap_q;
							cp = cw; cn = c1;
							if (c1 < 5'd4) byte_out = 1'b1;
							else begin
								fin = 1'b1; fst = (cw[7:6] != 2'b11) ? ST_FAIL : ST_OK;
							end
						end
						P_START: begin
							if (it.rx_byte != 8'hFF) begin
								if (it.rx_byte != 8'hFE) begin fin = 1'b1; fst = ST_FAIL; end
								else begin ph = P_CSD; cn = '0; cp = '0; byte_out = 1'b1; end
							end else if (wait_q < ctmo) byte_out = 1'b1;
							else begin fin = 1'b1; fst = ST_FAIL; end
						end
						P_CSD: begin
							cw = cap_q;
							if (cnt_q == 5'd7) cw = cap_q | {10'd0, it.rx_byte[5:0], 16'd0};
							else if (cnt_q == 5'd8) cw = cap_q | {16'd0, it.rx_byte, 8'd0};
							else if (cnt_q == 5'd9) cw = cap_q | {24'd0, it.rx_byte};
							cp = cw; cn = c1;
							if (c1 < 5'd18) byte_out = 1'b1;
							else begin
								fin = 1'b1; fst = ST_OK;
								fsz = {cw[22:0] + 23'd1, 10'd0};
							end
						end
						default: begin
							// command engine receive path
							if (stage_q == CS_IDLEWAIT) begin
								if (it.rx_byte == 8'hFF) begin st = CS_SEND; cn = '0; end
								need_poll = 1'b1;
							end else if (stage_q == CS_SEND) begin
								cn = c1;
								if (c1 >= 5'd6) begin st = CS_RESP; wt = '0; rs = 8'hFF; end
								need_poll = 1'b1;
							end else begin
								rs = it.rx_byte;
								if (it.rx_byte[7]) need_poll = 1'b1;
								else need_after = 1'b1;
							end
						end
					endcase
				end
			end
			default: ;
		endcase

		// start of a command: stage idle-wait then poll
		if (need_start) begin
			ix = si; ag = sa; st = CS_IDLEWAIT; wt = '0; need_poll = 1'b1;
		end
		if (need_poll) begin
			if (st == CS_SEND) begin
				byte_out = 1'b1;
				case (cn)
					5'd0: b = {2'b01, ix};
					5'd1: b = ag[31:24];
					5'd2: b = ag[23:16];
					5'd3: b = ag[15:8];
					5'd4: b = ag[7:0];
					default: b = (ix == 6'd0) ? 8'h95 : (ix == 6'd8) ? 8'h87 : 8'hFF;
				endcase
			end else if (wt < ctmo) byte_out = 1'b1;
			else begin
				if (st == CS_IDLEWAIT) rs = 8'hFF;
				need_after = 1'b1;
			end
		end
		if (need_after) begin
			// after_cmd: next command at most a single start poll (never recursive)
			case (ph)
				P_CMD0: begin
					if (rs == 8'h01) begin ph = P_CMD8; ix = 6'd8; ag = 32'h1AA; end
					else if (lp < itmo) begin ph = P_CMD0; ix = 6'd0; ag = '0; end
					else fin = 1'b1;
				end
				P_CMD8: begin
					if (rs[2]) fin = 1'b1;
					else begin ph = P_R7; cn = '0; cp = '0; byte_out = 1'b1; end
				end
				P_CMD55: begin ph = P_ACMD41; ix = 6'd41; ag = 32'h4000_0000; end
				P_ACMD41: begin
					if (rs == 8'h00) begin
						if (!it.card_present) begin fin = 1'b1; fst = ST_ABSENT; end
						else begin ph = P_CMD58; ix = 6'd58; ag = '0; end
					end else if (lp < itmo) begin ph = P_CMD55; ix = 6'd55; ag = '0; end
					else fin = 1'b1;
				end
				P_CMD58: begin
					if (rs != 8'h00) fin = 1'b1;
					else begin ph = P_OCR; cn = '0; cp = '0; byte_out = 1'b1; end
				end
				P_CMD9: begin
					if (rs != 8'h00) fin = 1'b1;
					else begin
						ph = P_START; wt = '0;
						if (16'd0 < ctmo) byte_out = 1'b1; else fin = 1'b1;
					end
				end
				default: begin fin = 1'b1; fst = rs[7] ? ST_FAIL : ST_OK; end
			endcase
			if (fin && ph != P_SINGLE && fst != ST_ABSENT) fst = ST_FAIL;
			if (!fin && !byte_out) begin
				// restarted command: idle wait with a fresh timer always sends 0xff
				st = CS_IDLEWAIT; wt = '0; byte_out = 1'b1;
			end
		end
		if (fin) ph = P_IDLE;
		res.tx_valid = byte_out;
		res.tx_byte = byte_out ? b : 8'hFF;
		res.select_active = byte_out;
		res.select_card = cd;
		res.done_res = !byte_out;
		res.status = byte_out ? ST_OK : fst;
		res.response_byte = rs;
		res.card_size_blocks = byte_out ? 33'd0 : fsz;
	end
endmodule

>>> rtl/sdspi_outreg.sv
// output register with skid stage for result words
// depends on sdspi_pkg
module sdspi_outreg import sdspi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input result_t in_res,
	output logic can_take,
	output logic out_vld,
	output result_t out_res,
	input logic out_stall
);
	logic skid_vld_q;
	result_t skid_q;
	assign can_take = !skid_vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0; skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld || !out_stall) begin
				out_vld <= skid_vld_q || in_vld;
				skid_vld_q <= 1'b0;
			end else if (in_vld) begin
				skid_vld_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (!out_vld || !out_stall) out_res <= skid_vld_q ? skid_q : in_res;
		if (in_vld && !skid_vld_q) skid_q <= in_res;
	end
endmodule

>>> rtl/sdspi_checker.sv
`include "sd_spi_init_command_engine_top_defines.svh"
// port-level checker for the sd spi command engine, bound to the top level
// depends on sdspi_pkg and sd_spi_init_command_engine_top_defines.svh
module sdspi_checker import sdspi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic tx_valid,
	input logic done_res,
	input logic select_active,
	input logic [1:0] status,
	input logic [7:0] tx_byte
);
	`SDE_ASSERT_IMP(a_one_kind, clk, arst_n, out_valid, tx_valid != done_res)
	`SDE_ASSERT_IMP(a_sel, clk, arst_n, out_valid, select_active == tx_valid)
	`SDE_ASSERT_IMP(a_byte_ok, clk, arst_n, out_valid && tx_valid, status == ST_OK)
	`SDE_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(tx_byte))
endmodule
bind sd_spi_init_command_engine_top sdspi_checker u_chk (.clk, .arst_n, .out_valid,
	.out_stall, .tx_valid, .done_res, .select_active, .status, .tx_byte);

>>> sim/sd_spi_init_command_engine_top_test.sv
// self-checking testbench for the sd spi init and command sequencer
// depends on sdspi_pkg and sd_spi_init_command_engine_top; a built-in card responder drives words
`timescale 1ns / 100ps

module sd_spi_init_command_engine_top_test;
	import sdspi_pkg::*;

	typedef struct {
		item_t word;
		bit typed;
		result_t known;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] command = CMD_TICK;
	logic card = 1'b0;
	logic [5:0] cmd_index = '0;
	logic [31:0] cmd_arg = '0;
	logic [7:0] rx_byte = '0;
	logic card_present = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic select_active;
	logic select_card;
	logic done_res;
	logic [1:0] status;
	logic [7:0] response_byte;
	logic [32:0] card_size_blocks;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_INIT_TMO;
	logic [15:0] cfg_data = '0;

	sd_spi_init_command_engine_top u_top (.*);

	// sequencer mirror
	phase_t ph;
	cstage_t cst;
	logic [15:0] wait_ticks, loop_ticks, init_limit, cmd_limit;
	int nbyte;
	logic [7:0] last_r1;
	logic [31:0] capw, cur_arg;
	logic [5:0] cur_idx;
	logic cur_card;
	logic [1:0] end_status;
	logic [32:0] end_size;

	result_t expected_words[$];
	row_t rows[$];
	int errors = 0;
	int burst_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("sd_spi_init_command_engine_top_test: done, errors");
		$finish;
	end

	function int finish_seq(logic [1:0] st, logic [32:0] sz);
		end_status = st;
		end_size = sz;
		ph = P_IDLE;
		return -1;
	endfunction

	function int cmd_lim();
		return (cmd_limit == 0) ? 1 : int'(cmd_limit);
	endfunction

	function int init_lim();
		return (init_limit == 0) ? 1 : int'(init_limit);
	endfunction

	function int frame_byte(int n);
		case (n)
			0: return {2'b01, cur_idx};
			1: return cur_arg[31:24];
			2: return cur_arg[23:16];
			3: return cur_arg[15:8];
			4: return cur_arg[7:0];
			default: begin
				if (cur_idx == 0) return 'h95;
				if (cur_idx == 8) return 'h87;
				return 'hFF;
			end
		endcase
	endfunction

	function int frame_poll();
		if (cst == CS_SEND) return frame_byte(nbyte);
		if (int'(wait_ticks) < cmd_lim()) return 'hFF;
		if (cst == CS_IDLEWAIT) last_r1 = 8'hFF;
		return -1;
	endfunction

	function int frame_start(logic [5:0] idx, logic [31:0] arg);
		cur_idx = idx;
		cur_arg = arg;
		cst = CS_IDLEWAIT;
		wait_ticks = 0;
		return frame_poll();
	endfunction

	function int frame_rx(logic [7:0] rx);
		if (cst == CS_IDLEWAIT) begin
			if (rx == 8'hFF) begin
				cst = CS_SEND;
				nbyte = 0;
			end
		end else if (cst == CS_SEND) begin
			nbyte++;
			if (nbyte >= 6) begin
				cst = CS_RESP;
				wait_ticks = 0;
				last_r1 = 8'hFF;
			end
		end else begin
			last_r1 = rx;
			if (!rx[7]) return -1;
		end
		return frame_poll();
	endfunction

	function int retry_cmd0();
		if (int'(loop_ticks) < init_lim()) begin
			ph = P_CMD0;
			return frame_start(0, 0);
		end
		return finish_seq(ST_FAIL, 0);
	endfunction

	function int retry_acmd41();
		if (int'(loop_ticks) < init_lim()) begin
			ph = P_CMD55;
			return frame_start(55, 0);
		end
		return finish_seq(ST_FAIL, 0);
	endfunction

	function int token_poll();
		if (int'(wait_ticks) < cmd_lim()) return 'hFF;
		return finish_seq(ST_FAIL, 0);
	endfunction

	function int after_frame(logic present);
		case (ph)
			P_CMD0: begin
				if (last_r1 == 8'h01) begin
					ph = P_CMD8;
					return frame_start(8, 32'h1AA);
				end
				return retry_cmd0();
			end
			P_CMD8: begin
				if (last_r1[2]) return finish_seq(ST_FAIL, 0);
				ph = P_R7;
				nbyte = 0;
				capw = 0;
				return 'hFF;
			end
			P_CMD55: begin
				ph = P_ACMD41;
				return frame_start(41, 32'h4000_0000);
			end
			P_ACMD41: begin
				if (last_r1 == 0) begin
					if (!present) return finish_seq(ST_ABSENT, 0);
					ph = P_CMD58;
					return frame_start(58, 0);
				end
				return retry_acmd41();
			end
			P_CMD58: begin
				if (last_r1 != 0) return finish_seq(ST_FAIL, 0);
				ph = P_OCR;
				nbyte = 0;
				capw = 0;
				return 'hFF;
			end
			P_CMD9: begin
				if (last_r1 != 0) return finish_seq(ST_FAIL, 0);
				ph = P_START;
				wait_ticks = 0;
				return token_poll();
			end
			default: return finish_seq(last_r1[7] ? ST_FAIL : ST_OK, 0);
		endcase
	endfunction

	function int take_byte(logic [7:0] rx, logic present);
		int nx;
		case (ph)
			P_R7: begin
				capw = {capw[23:0], rx};
				nbyte++;
				if (nbyte < 4) return 'hFF;
				if (capw[7:0] != 8'hAA) return finish_seq(ST_FAIL, 0);
				if (!present) return finish_seq(ST_ABSENT, 0);
				loop_ticks = 0;
				return retry_acmd41();
			end
			P_OCR: begin
				if (nbyte == 0) capw = {24'd0, rx};
				nbyte++;
				if (nbyte < 4) return 'hFF;
				if (capw[7:6] != 2'b11) return finish_seq(ST_FAIL, 0);
				return finish_seq(ST_OK, 0);
			end
			P_START: begin
				if (rx != 8'hFF) begin
					if (rx != 8'hFE) return finish_seq(ST_FAIL, 0);
					ph = P_CSD;
					nbyte = 0;
					capw = 0;
					return 'hFF;
				end
				return token_poll();
			end
			P_CSD: begin
				if (nbyte == 7) capw = capw | {10'd0, rx[5:0], 16'd0};
				else if (nbyte == 8) capw = capw | {16'd0, rx, 8'd0};
				else if (nbyte == 9) capw = capw | {24'd0, rx};
				nbyte++;
				if (nbyte < 18) return 'hFF;
				return finish_seq(ST_OK, (33'(capw) + 33'd1) << 10);
			end
			default: begin
				nx = frame_rx(rx);
				if (nx >= 0) return nx;
				return after_frame(present);
			end
		endcase
	endfunction

	task predict_word(input item_t w, output bit has, output result_t r);
		int nx;
		has = 0;
		r = '0;
		if (w.command == CMD_TICK) begin
			if (wait_ticks != 16'hFFFF) wait_ticks++;
			if (loop_ticks != 16'hFFFF) loop_ticks++;
			return;
		end else if (w.command == CMD_RX) begin
			if (ph == P_IDLE) return;
			nx = take_byte(w.rx_byte, w.card_present);
		end else if (w.command <= CMD_SINGLE) begin
			if (ph != P_IDLE) return;
			cur_card = w.card;
			last_r1 = 8'hFF;
			if (w.command == CMD_INIT) begin
				if (!w.card_present) nx = finish_seq(ST_ABSENT, 0);
				else begin
					loop_ticks = 0;
					nx = retry_cmd0();
				end
			end else if (w.command == CMD_SIZE) begin
				if (!w.card_present) nx = finish_seq(ST_ABSENT, 0);
				else begin
					ph = P_CMD9;
					nx = frame_start(9, 0);
				end
			end else begin
				ph = P_SINGLE;
				nx = frame_start(w.cmd_index, w.cmd_arg);
			end
		end else begin
			return;
		end
		has = 1;
		r.select_card = cur_card;
		r.response_byte = last_r1;
		if (nx >= 0) begin
			r.tx_valid = 1;
			r.tx_byte = nx[7:0];
			r.select_active = 1;
		end else begin
			r.tx_byte = 8'hFF;
			r.done_res = 1;
			r.status = end_status;
			r.card_size_blocks = end_size;
		end
	endtask

	function item_t make_word(logic [2:0] c, logic cd, logic [5:0] idx, logic [31:0] arg,
			logic [7:0] rx, logic pres);
		item_t w;
		w.command = c;
		w.card = cd;
		w.cmd_index = idx;
		w.cmd_arg = arg;
		w.rx_byte = rx;
		w.card_present = pres;
		return w;
	endfunction

	function void add_row(item_t w, bit typed = 0, result_t known = '0);
		row_t rw;
		rw.word = w;
		rw.typed = typed;
		rw.known = known;
		rows.push_back(rw);
	endfunction

	// plausible card answer for the current sequencer position, with some noise
	function logic [7:0] card_answer();
		int p;
		p = $urandom_range(99);
		if (p < 6) return $urandom;
		case (ph)
			P_R7: return (nbyte == 3 && p < 92) ? 8'hAA : 8'($urandom);
			P_OCR: return (nbyte == 0 && p < 90) ? (8'hC0 | 8'($urandom)) : 8'($urandom);
			P_START: return (p < 50) ? 8'hFF : (p < 94) ? 8'hFE : 8'($urandom);
			P_CSD: return $urandom;
			default: ;
		endcase
		if (cst == CS_IDLEWAIT) return (p < 80) ? 8'hFF : 8'h00;
		if (cst == CS_SEND) return $urandom;
		if (p < 30) return 8'hFF;
		case (ph)
			P_CMD0: return (p < 80) ? 8'h01 : 8'h00;
			P_CMD8: return (p < 90) ? 8'h01 : 8'h05;
			P_CMD55: return 8'h01;
			P_ACMD41: return (p < 65) ? 8'h00 : 8'h01;
			P_CMD58, P_CMD9: return (p < 92) ? 8'h00 : 8'h04;
			default: return $urandom_range(127);
		endcase
	endfunction

	task send_word(input item_t w, input bit typed, input result_t known);
		bit has;
		result_t r;
		in_valid <= 1'b1;
		command <= w.command;
		card <= w.card;
		cmd_index <= w.cmd_index;
		cmd_arg <= w.cmd_arg;
		rx_byte <= w.rx_byte;
		card_present <= w.card_present;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_word(w, has, r);
		if (has) expected_words.push_back(typed ? known : r);
		if (burst_left > 0) burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 150) : $urandom_range(20);
		end
	endtask

	task write_reg(input logic idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == REG_INIT_TMO) init_limit = v;
		else cmd_limit = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function item_t random_word();
		int p;
		logic pres;
		p = $urandom_range(99);
		pres = ($urandom_range(19) != 0);
		if (ph == P_IDLE && p < 85)
			return make_word(3'($urandom_range(CMD_SINGLE)), $urandom, $urandom, $urandom,
				$urandom, pres);
		if (p < 88) return make_word(CMD_RX, $urandom, $urandom, $urandom, card_answer(), pres);
		if (p < 97) return make_word(CMD_TICK, $urandom, $urandom, $urandom, $urandom, pres);
		return make_word(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom, pres);
	endfunction

	task check_field(input string name, input logic [32:0] e, input logic [32:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got tx %0h done %0b", $time,
					tx_byte, done_res);
				errors++;
			end else begin
				e = expected_words.pop_front();
				check_field("tx_valid", e.tx_valid, tx_valid);
				check_field("tx_byte", e.tx_byte, tx_byte);
				check_field("select_active", e.select_active, select_active);
				check_field("select_card", e.select_card, select_card);
				check_field("done_res", e.done_res, done_res);
				check_field("status", e.status, status);
				check_field("response_byte", e.response_byte, response_byte);
				check_field("card_size_blocks", e.card_size_blocks, card_size_blocks);
			end
		end
	end

	// receiver stall pattern, with one long hold to back the block up
	initial begin
		int cyc;
		int hold;
		cyc = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 300) hold = 400;
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				case ((cyc / 97) % 3)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(99) < 35);
					default: out_stall <= cyc[1];
				endcase
			end
		end
	end

	initial begin
		logic [15:0] init_set[6];
		logic [15:0] cmd_set[6];
		result_t absent0, absent1, first_poll;
		init_set = '{16'd2000, 16'd1, 16'd3, 16'd65535, 16'd0, 16'd6};
		cmd_set = '{16'd300, 16'd1, 16'd2, 16'd65535, 16'd0, 16'd5};
		ph = P_IDLE;
		cst = CS_IDLEWAIT;
		wait_ticks = 0;
		loop_ticks = 0;
		nbyte = 0;
		last_r1 = 8'hFF;
		capw = 0;
		cur_arg = 0;
		cur_idx = 0;
		cur_card = 0;
		end_status = ST_OK;
		end_size = 0;
		init_limit = INIT_TMO_RST;
		cmd_limit = CMD_TMO_RST;

		absent0 = '{1'b0, 8'hFF, 1'b0, 1'b0, 1'b1, ST_ABSENT, 8'hFF, 33'd0};
		absent1 = '{1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, ST_ABSENT, 8'hFF, 33'd0};
		first_poll = '{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, ST_OK, 8'hFF, 33'd0};
		add_row(make_word(CMD_INIT, 0, 0, 0, 0, 0), 1, absent0);
		add_row(make_word(CMD_SIZE, 1, '1, '1, '1, 0), 1, absent1);
		add_row(make_word(CMD_TICK, 0, 0, 0, 0, 1));
		add_row(make_word(CMD_RX, 0, 0, 0, 8'hFF, 1));
		add_row(make_word(3'd5, 1, '1, '1, '1, 1));
		add_row(make_word(3'd6, 0, 0, 0, 0, 0));
		add_row(make_word(3'd7, 1, '1, '1, '1, 1));
		add_row(make_word(CMD_SINGLE, 1, 6'd63, 32'hFFFF_FFFF, 0, 0), 1, first_poll);
		add_row(make_word(CMD_INIT, 0, 0, 0, 0, 1));
		add_row(make_word(CMD_RX, 0, 0, 0, 8'hFF, 0));
		repeat (6) add_row(make_word(CMD_RX, 0, 0, 0, 8'h00, 0));
		add_row(make_word(CMD_RX, 0, 0, 0, 8'h80, 0));
		add_row(make_word(CMD_RX, 0, 0, 0, 8'h00, 0));
		add_row(make_word(CMD_SINGLE, 0, 0, 0, 0, 1));
		add_row(make_word(CMD_RX, 0, 0, 0, 8'hFF, 1));
		repeat (5) add_row(make_word(CMD_RX, 0, 0, 0, 8'h55, 1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_reg(REG_INIT_TMO, init_set[0]);
		write_reg(REG_CMD_TMO, cmd_set[0]);
		foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].known);

		for (int s = 0; s < 6; s++) begin
			if (s > 0) begin
				in_valid <= 1'b0;
				drain();
				write_reg(REG_INIT_TMO, init_set[s]);
				write_reg(REG_CMD_TMO, cmd_set[s]);
			end
			repeat (215) send_word(random_word(), 0, '0);
		end
		in_valid <= 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) $display("sd_spi_init_command_engine_top_test: done, clean");
		else $display("sd_spi_init_command_engine_top_test: done, errors");
		$finish;
	end
endmodule
